// File: src/p2tr_pkg.sv
package p2tr_pkg;

    // Source geometry and frame store sizing.
    localparam int MAX_SRC_DIM  = 256;
    localparam int DIM_W        = 9;
    localparam int LOG2_CEILING = 8;
    localparam int STORE_DEPTH  = MAX_SRC_DIM * MAX_SRC_DIM;
    localparam int ADDR_W       = $clog2(STORE_DEPTH);
    localparam int AREA_W       = ADDR_W + 1;
    localparam int PIX_W        = 24;

    // Command queue between the front end and the back end.
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = FIFO_AW + 1;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        CFG_TEX_MAX_LOG2 = 2'd0,
        CFG_SRC_WIDTH    = 2'd1,
        CFG_SRC_HEIGHT   = 2'd2,
        CFG_SRC_IS_GRAY  = 2'd3
    } t_cfg_index;

    typedef struct packed {
        logic [3:0]       tex_max_log2;
        logic [DIM_W-1:0] src_width;
        logic [DIM_W-1:0] src_height;
        logic             src_is_gray;
    } t_cfg;

    // One classified item as it travels from the front end to the back end.
    typedef struct packed {
        logic             is_read;
        logic             oor;
        logic [PIX_W-1:0] pix;
        logic [7:0]       sx;
        logic [7:0]       sy;
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
    } t_cmd;

    // Source dimensions above the store limit act as the limit.
    function automatic logic [DIM_W-1:0] f_clamp_dim(input logic [DIM_W-1:0] d);
        return (d > DIM_W'(MAX_SRC_DIM)) ? DIM_W'(MAX_SRC_DIM) : d;
    endfunction

    // Smallest k with 2^k >= d, capped by the configured limit (and by 8).
    function automatic logic [3:0] f_tex_log2(input logic [DIM_W-1:0] d,
                                              input logic [3:0]       cap);
        logic [3:0] k;
        logic [3:0] c;
        k = '0;
        c = (cap > 4'(LOG2_CEILING)) ? 4'(LOG2_CEILING) : cap;
        for (int i = LOG2_CEILING; i >= 0; i--) begin
            if (d <= (DIM_W'(1) << i)) begin
                k = 4'(i);
            end
        end
        return (k > c) ? c : k;
    endfunction

endpackage

// File: src/p2tr_front.sv
module p2tr_front (
    input  logic              i_valid,
    input  logic              i_full,
    input  logic              i_mode,
    input  logic [7:0]        i_pixel_red,
    input  logic [7:0]        i_pixel_green,
    input  logic [7:0]        i_pixel_blue,
    input  logic [7:0]        i_tex_col,
    input  logic [7:0]        i_tex_row,
    input  p2tr_pkg::t_cfg    i_cfg,
    output logic              o_push,
    output p2tr_pkg::t_cmd    o_cmd
);
    import p2tr_pkg::*;

    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [3:0]       lw;
    logic [3:0]       lh;
    logic [DIM_W-1:0] tw;
    logic [DIM_W-1:0] th;
    logic [DIM_W-1:0] row_flip;
    logic [16:0]      prod_x;
    logic [16:0]      prod_y;
    logic [16:0]      shr_x;
    logic [16:0]      shr_y;

    // Texture dimensions follow from the current source size and limit.
    always_comb begin
        w  = f_clamp_dim(i_cfg.src_width);
        h  = f_clamp_dim(i_cfg.src_height);
        lw = f_tex_log2(w, i_cfg.tex_max_log2);
        lh = f_tex_log2(h, i_cfg.tex_max_log2);
        tw = DIM_W'(1) << lw;
        th = DIM_W'(1) << lh;
    end

    // Flip Y and scale both coordinates to the source grid.
    always_comb begin
        row_flip = th - DIM_W'(1) - {1'b0, i_tex_row};
        prod_x   = 17'(i_tex_col) * 17'(w);
        prod_y   = 17'(row_flip[7:0]) * 17'(h);
        shr_x    = prod_x >> lw;
        shr_y    = prod_y >> lh;
    end

    // Classify the item and hand it to the queue.
    always_comb begin
        o_push        = i_valid && !i_full;
        o_cmd.is_read = i_mode;
        o_cmd.oor     = ({1'b0, i_tex_col} >= tw) || ({1'b0, i_tex_row} >= th);
        o_cmd.pix     = {i_pixel_red, i_pixel_green, i_pixel_blue};
        o_cmd.sx      = shr_x[7:0];
        o_cmd.sy      = shr_y[7:0];
        o_cmd.tw      = tw;
        o_cmd.th      = th;
    end

endmodule

// File: src/p2tr_fifo.sv
module p2tr_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  p2tr_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_full,
    output logic           o_empty,
    output p2tr_pkg::t_cmd o_cmd
);
    import p2tr_pkg::*;

    t_cmd               r_entry [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_CW-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == FIFO_CW'(FIFO_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_entry[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + FIFO_CW'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - FIFO_CW'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// File: src/p2tr_back.sv
module p2tr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  p2tr_pkg::t_cfg i_cfg,
    input  logic           i_empty,
    input  p2tr_pkg::t_cmd i_cmd,
    output logic           o_pop,
    input  logic           i_stall,
    output logic           o_valid,
    output logic [7:0]     o_out_red,
    output logic [7:0]     o_out_green,
    output logic [7:0]     o_out_blue,
    output logic [8:0]     o_tex_width,
    output logic [8:0]     o_tex_height,
    output logic           o_out_of_range
);
    import p2tr_pkg::*;

    logic [PIX_W-1:0]  r_store [STORE_DEPTH];
    logic [ADDR_W-1:0] r_load_addr;
    logic [AREA_W-1:0] r_area;
    logic              r_v1;
    logic              r_v2;
    logic              r_v3;
    t_cmd              r_s1;
    t_cmd              r_s2;
    logic [ADDR_W-1:0] r_s1_addr;
    logic [PIX_W-1:0]  r_rdata;
    logic [7:0]        r_out_red;
    logic [7:0]        r_out_green;
    logic [7:0]        r_out_blue;
    logic [8:0]        r_tex_width;
    logic [8:0]        r_tex_height;
    logic              r_out_of_range;

    logic              en;
    logic [DIM_W-1:0]  w;
    logic [DIM_W-1:0]  h;
    logic [AREA_W-1:0] n_inc;
    logic [ADDR_W-1:0] n_load_addr;
    logic [16:0]       row_base;
    logic [16:0]       read_sum;

    // The whole back pipeline holds while a result waits on a stalled receiver.
    assign en    = !(r_v3 && i_stall);
    assign o_pop = en && !i_empty;

    assign w = f_clamp_dim(i_cfg.src_width);
    assign h = f_clamp_dim(i_cfg.src_height);

    // Next load address wraps once it reaches the source area.
    always_comb begin
        n_inc       = {1'b0, r_load_addr} + AREA_W'(1);
        n_load_addr = (n_inc >= r_area) ? '0 : n_inc[ADDR_W-1:0];
        row_base    = 17'(i_cmd.sy) * 17'(w);
        read_sum    = row_base + 17'(i_cmd.sx);
    end

    // Source area, held in a register after its multiplier.
    always_ff @(posedge i_clk) begin
        r_area <= AREA_W'(w) * AREA_W'(h);
    end

    // Stage valids and the load address counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_load_addr <= '0;
        end else if (en) begin
            r_v1 <= o_pop;
            r_v2 <= r_v1;
            r_v3 <= r_v2 && r_s2.is_read;
            if (o_pop && !i_cmd.is_read) begin
                r_load_addr <= n_load_addr;
            end
        end
    end

    // Address stage: loads take the counter, reads take row * width + column.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1      <= i_cmd;
            r_s1_addr <= i_cmd.is_read ? read_sum[ADDR_W-1:0] : r_load_addr;
            r_s2      <= r_s1;
        end
    end

    // Frame store: one write or one registered read per cycle, held while stalled.
    always_ff @(posedge i_clk) begin
        if (en && r_v1) begin
            if (r_s1.is_read) begin
                r_rdata <= r_store[r_s1_addr];
            end else begin
                r_store[r_s1_addr] <= r_s1.pix;
            end
        end
    end

    // Output register: gray expansion and zeroing of out-of-range reads.
    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r_s2.oor) begin
                r_out_red   <= '0;
                r_out_green <= '0;
                r_out_blue  <= '0;
            end else if (i_cfg.src_is_gray) begin
                r_out_red   <= r_rdata[23:16];
                r_out_green <= r_rdata[23:16];
                r_out_blue  <= r_rdata[23:16];
            end else begin
                r_out_red   <= r_rdata[23:16];
                r_out_green <= r_rdata[15:8];
                r_out_blue  <= r_rdata[7:0];
            end
            r_tex_width    <= r_s2.tw;
            r_tex_height   <= r_s2.th;
            r_out_of_range <= r_s2.oor;
        end
    end

    assign o_valid        = r_v3;
    assign o_out_red      = r_out_red;
    assign o_out_green    = r_out_green;
    assign o_out_blue     = r_out_blue;
    assign o_tex_width    = r_tex_width;
    assign o_tex_height   = r_tex_height;
    assign o_out_of_range = r_out_of_range;

endmodule

// File: src/pow2_texture_nearest_resample.sv
// Nearest-neighbor resampler from a source image to a power-of-two texture.
// Input channel (i_valid / o_stall): each item either loads the next source
// pixel in raster order (i_mode low) or reads one texture pixel at
// (i_tex_col, i_tex_row), row 0 at the bottom (i_mode high). Loads give no
// result; each read gives exactly one result item on the output channel
// (o_valid / i_stall) with the color, the texture dimensions and an
// out-of-range flag.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_data; the
// user must write it only while the block is idle; the block does not enforce this.
// A read passes the queue, then the address, store read and output registers.
// Throughput: one item per cycle while the receiver does not stall, bounded
// by the single frame store port (one load write or one read per cycle).
// A four-entry queue separates the front end from the back end, so items are
// still taken while a result waits; when the receiver stalls, the result
// holds and the back end freezes, and o_stall rises once the queue fills.
// Reset clears the load address, the queue and the pipeline, and restores
// the register defaults. The frame store is not cleared; entries read before
// being loaded return undefined colors.
module pow2_texture_nearest_resample (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic       i_mode,
    input  logic [7:0] i_pixel_red,
    input  logic [7:0] i_pixel_green,
    input  logic [7:0] i_pixel_blue,
    input  logic [7:0] i_tex_col,
    input  logic [7:0] i_tex_row,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [7:0] o_out_red,
    output logic [7:0] o_out_green,
    output logic [7:0] o_out_blue,
    output logic [8:0] o_tex_width,
    output logic [8:0] o_tex_height,
    output logic       o_out_of_range,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data
);
    import p2tr_pkg::*;

    t_cfg r_cfg;
    t_cmd push_cmd;
    t_cmd head_cmd;
    logic push;
    logic pop;
    logic full;
    logic empty;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tex_max_log2 <= 4'(LOG2_CEILING);
            r_cfg.src_width    <= DIM_W'(MAX_SRC_DIM);
            r_cfg.src_height   <= DIM_W'(MAX_SRC_DIM);
            r_cfg.src_is_gray  <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_TEX_MAX_LOG2: r_cfg.tex_max_log2 <= i_cfg_data[3:0];
                CFG_SRC_WIDTH:    r_cfg.src_width    <= i_cfg_data;
                CFG_SRC_HEIGHT:   r_cfg.src_height   <= i_cfg_data;
                CFG_SRC_IS_GRAY:  r_cfg.src_is_gray  <= i_cfg_data[0];
            endcase
        end
    end

    assign o_stall = full;

    p2tr_front u_front (
        .i_valid       (i_valid),
        .i_full        (full),
        .i_mode        (i_mode),
        .i_pixel_red   (i_pixel_red),
        .i_pixel_green (i_pixel_green),
        .i_pixel_blue  (i_pixel_blue),
        .i_tex_col     (i_tex_col),
        .i_tex_row     (i_tex_row),
        .i_cfg         (r_cfg),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    p2tr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_full  (full),
        .o_empty (empty),
        .o_cmd   (head_cmd)
    );

    p2tr_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_empty        (empty),
        .i_cmd          (head_cmd),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_tex_width    (o_tex_width),
        .o_tex_height   (o_tex_height),
        .o_out_of_range (o_out_of_range)
    );

endmodule

// File: sim/texture_read_checker.sv
module texture_read_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic       i_mode,
    input  logic [7:0] i_pixel_red,
    input  logic [7:0] i_pixel_green,
    input  logic [7:0] i_pixel_blue,
    input  logic [7:0] i_tex_col,
    input  logic [7:0] i_tex_row,
    input  logic       i_res_valid,
    input  logic       i_res_stall,
    input  logic [7:0] i_res_red,
    input  logic [7:0] i_res_green,
    input  logic [7:0] i_res_blue,
    input  logic [8:0] i_res_width,
    input  logic [8:0] i_res_height,
    input  logic       i_res_oor,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [8:0] i_cfg_data,
    output int         o_mismatches,
    output int         o_awaiting
);
    import p2tr_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // One texel as it leaves the block.
    typedef struct packed {
        logic [7:0]       red;
        logic [7:0]       green;
        logic [7:0]       blue;
        logic [DIM_W-1:0] width;
        logic [DIM_W-1:0] height;
        logic             oor;
    } t_texel;

    // Private copy of the frame store, the load pointer and the registers.
    logic [PIX_W-1:0] frame_mem [STORE_DEPTH];
    int unsigned      next_load;
    logic [3:0]       cap_log2;
    logic [DIM_W-1:0] cfg_width;
    logic [DIM_W-1:0] cfg_height;
    logic             cfg_gray;
    t_texel           awaited_texels [$];

    // Source sizes beyond the store act as the store size.
    function automatic int unsigned clamp_side(logic [DIM_W-1:0] d);
        return (d > MAX_SRC_DIM) ? MAX_SRC_DIM : d;
    endfunction

    // Log2 of the texture side: smallest power of two covering the source, capped.
    function automatic int unsigned side_log2(int unsigned d);
        int unsigned limit;
        int unsigned k;
        limit = (cap_log2 > LOG2_CEILING) ? LOG2_CEILING : cap_log2;
        k = 0;
        while (k < limit && (32'd1 << k) < d) begin
            k++;
        end
        return k;
    endfunction

    // Texel that a read of (col, row) returns, with row 0 at the bottom.
    function automatic t_texel sample_texel(logic [7:0] col, logic [7:0] row);
        int unsigned      w;
        int unsigned      h;
        int unsigned      lw;
        int unsigned      lh;
        int unsigned      tw;
        int unsigned      th;
        int unsigned      sx;
        int unsigned      sy;
        logic [PIX_W-1:0] pix;
        t_texel           t;
        w  = clamp_side(cfg_width);
        h  = clamp_side(cfg_height);
        lw = side_log2(w);
        lh = side_log2(h);
        tw = 32'd1 << lw;
        th = 32'd1 << lh;
        t = '0;
        t.width  = DIM_W'(tw);
        t.height = DIM_W'(th);
        if (col >= tw || row >= th) begin
            t.oor = 1'b1;
        end else begin
            sx  = (col * w) >> lw;
            sy  = ((th - 1 - row) * h) >> lh;
            pix = frame_mem[(sy * w + sx) % STORE_DEPTH];
            t.red = pix[23:16];
            if (cfg_gray) begin
                t.green = pix[23:16];
                t.blue  = pix[23:16];
            end else begin
                t.green = pix[15:8];
                t.blue  = pix[7:0];
            end
        end
        return t;
    endfunction

    // A load writes at the pointer, which wraps once it reaches the source area.
    function automatic void store_pixel(logic [7:0] red, logic [7:0] green,
                                        logic [7:0] blue);
        int unsigned a;
        a = next_load % STORE_DEPTH;
        frame_mem[a] = {red, green, blue};
        a++;
        next_load = (a >= clamp_side(cfg_width) * clamp_side(cfg_height)) ? 0 : a;
    endfunction

    // Results are checked before new items are predicted, so a result that
    // arrives with nothing outstanding is always caught.
    always @(posedge i_clk) begin
        t_texel got;
        t_texel want;
        if (!i_rst_n) begin
            next_load  = 0;
            cap_log2   = 4'd8;
            cfg_width  = DIM_W'(256);
            cfg_height = DIM_W'(256);
            cfg_gray   = 1'b0;
            awaited_texels.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got = {i_res_red, i_res_green, i_res_blue, i_res_width, i_res_height,
                       i_res_oor};
                if (awaited_texels.size() == 0) begin
                    if (o_mismatches < REPORT_LIMIT) begin
                        $display("Unexpected result item: rgb %02h %02h %02h size %0dx%0d oor %0b",
                                 got.red, got.green, got.blue, got.width, got.height,
                                 got.oor);
                    end
                    o_mismatches++;
                end else begin
                    want = awaited_texels.pop_front();
                    if (got !== want) begin
                        if (o_mismatches < REPORT_LIMIT) begin
                            $display("Result mismatch at %0t:", $realtime);
                            $display("  expected rgb %02h %02h %02h size %0dx%0d oor %0b",
                                     want.red, want.green, want.blue, want.width,
                                     want.height, want.oor);
                            $display("  actual   rgb %02h %02h %02h size %0dx%0d oor %0b",
                                     got.red, got.green, got.blue, got.width, got.height,
                                     got.oor);
                        end
                        o_mismatches++;
                    end
                end
            end

            // Register writes.
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TEX_MAX_LOG2: cap_log2   = i_cfg_data[3:0];
                    CFG_SRC_WIDTH:    cfg_width  = i_cfg_data;
                    CFG_SRC_HEIGHT:   cfg_height = i_cfg_data;
                    CFG_SRC_IS_GRAY:  cfg_gray   = i_cfg_data[0];
                    default: ;
                endcase
            end

            // A read item expects one texel; a load item updates the store.
            if (i_in_valid && !i_in_stall) begin
                if (i_mode) begin
                    awaited_texels.push_back(sample_texel(i_tex_col, i_tex_row));
                end else begin
                    store_pixel(i_pixel_red, i_pixel_green, i_pixel_blue);
                end
            end
        end
        o_awaiting = awaited_texels.size();
    end

endmodule

// File: sim/pow2_texture_nearest_resample_tb.sv
module pow2_texture_nearest_resample_tb;
    import p2tr_pkg::*;

    localparam logic MODE_LOAD         = 1'b0;
    localparam logic MODE_READ         = 1'b1;
    localparam int   SETTLE_CYCLES     = 16;
    localparam int   QUIET_LIMIT       = 5000;
    localparam int   ITEMS_PER_SETTING = 50;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_valid       = 1'b0;
    logic       o_stall;
    logic       i_mode        = MODE_LOAD;
    logic [7:0] i_pixel_red   = '0;
    logic [7:0] i_pixel_green = '0;
    logic [7:0] i_pixel_blue  = '0;
    logic [7:0] i_tex_col     = '0;
    logic [7:0] i_tex_row     = '0;
    logic       o_valid;
    logic       i_stall       = 1'b0;
    logic [7:0] o_out_red;
    logic [7:0] o_out_green;
    logic [7:0] o_out_blue;
    logic [8:0] o_tex_width;
    logic [8:0] o_tex_height;
    logic       o_out_of_range;
    logic       i_cfg_we      = 1'b0;
    logic [1:0] i_cfg_index   = CFG_TEX_MAX_LOG2;
    logic [8:0] i_cfg_data    = '0;

    int mismatches;
    int awaiting;
    int tx_gap_pct   = 37;
    int rx_stall_pct = 66;
    int quiet_cycles = 0;

    // Which store entries have been loaded, and where the next load lands.
    // Reads are only aimed at loaded entries.
    bit          texel_loaded [STORE_DEPTH];
    int unsigned load_ptr  = 0;
    int unsigned cap_m     = 8;
    int unsigned width_m   = 256;
    int unsigned height_m  = 256;

    always #4 i_clk = ~i_clk;

    pow2_texture_nearest_resample u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_mode         (i_mode),
        .i_pixel_red    (i_pixel_red),
        .i_pixel_green  (i_pixel_green),
        .i_pixel_blue   (i_pixel_blue),
        .i_tex_col      (i_tex_col),
        .i_tex_row      (i_tex_row),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_red      (o_out_red),
        .o_out_green    (o_out_green),
        .o_out_blue     (o_out_blue),
        .o_tex_width    (o_tex_width),
        .o_tex_height   (o_tex_height),
        .o_out_of_range (o_out_of_range),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    texture_read_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_mode        (i_mode),
        .i_pixel_red   (i_pixel_red),
        .i_pixel_green (i_pixel_green),
        .i_pixel_blue  (i_pixel_blue),
        .i_tex_col     (i_tex_col),
        .i_tex_row     (i_tex_row),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_res_red     (o_out_red),
        .i_res_green   (o_out_green),
        .i_res_blue    (o_out_blue),
        .i_res_width   (o_tex_width),
        .i_res_height  (o_tex_height),
        .i_res_oor     (o_out_of_range),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_mismatches  (mismatches),
        .o_awaiting    (awaiting)
    );

    // Receiver back-pressure.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Watchdog: count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
    end

    function automatic int unsigned clamp_side(int unsigned d);
        return (d > MAX_SRC_DIM) ? MAX_SRC_DIM : d;
    endfunction

    function automatic int unsigned side_log2(int unsigned d);
        int unsigned limit;
        int unsigned k;
        limit = (cap_m > LOG2_CEILING) ? LOG2_CEILING : cap_m;
        k = 0;
        while (k < limit && (32'd1 << k) < d) begin
            k++;
        end
        return k;
    endfunction

    // Store entry that a read of (col, row) lands on, or -1 when outside the texture.
    function automatic int texel_address(logic [7:0] col, logic [7:0] row);
        int unsigned w;
        int unsigned h;
        int unsigned lw;
        int unsigned lh;
        int unsigned th;
        w  = clamp_side(width_m);
        h  = clamp_side(height_m);
        lw = side_log2(w);
        lh = side_log2(h);
        th = 32'd1 << lh;
        if (col >= (32'd1 << lw) || row >= th) begin
            return -1;
        end
        return int'((((((th - 1 - row) * h) >> lh) * w) + ((col * w) >> lw)) % STORE_DEPTH);
    endfunction

    // Present one item and hold it until it is taken.
    task automatic send_item(logic mode, logic [7:0] red, logic [7:0] green,
                             logic [7:0] blue, logic [7:0] col, logic [7:0] row);
        while ($urandom_range(99) < tx_gap_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_mode        <= mode;
        i_pixel_red   <= red;
        i_pixel_green <= green;
        i_pixel_blue  <= blue;
        i_tex_col     <= col;
        i_tex_row     <= row;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        @(negedge i_clk);
    endtask

    task automatic issue_load(logic [7:0] red, logic [7:0] green, logic [7:0] blue);
        int unsigned a;
        a = load_ptr % STORE_DEPTH;
        texel_loaded[a] = 1'b1;
        a++;
        load_ptr = (a >= clamp_side(width_m) * clamp_side(height_m)) ? 0 : a;
        send_item(MODE_LOAD, red, green, blue, 8'($urandom), 8'($urandom));
    endtask

    task automatic issue_read(logic [7:0] col, logic [7:0] row);
        send_item(MODE_READ, 8'($urandom), 8'($urandom), 8'($urandom), col, row);
    endtask

    // At least a quarter of the items are loads. Reads mix fully random coordinates,
    // coordinates inside the texture, and coordinates near the top-left of
    // the source, where loaded entries lie. A read that would hit an entry
    // never loaded is retried, and turned into a load if nothing fits.
    task automatic random_item();
        logic [7:0]  col;
        logic [7:0]  row;
        int          addr;
        bit          found;
        int unsigned tw;
        int unsigned th;
        int unsigned reach_c;
        int unsigned reach_r;
        found   = 1'b0;
        col     = '0;
        row     = '0;
        tw      = 32'd1 << side_log2(clamp_side(width_m));
        th      = 32'd1 << side_log2(clamp_side(height_m));
        reach_c = (tw > 8) ? 7 : tw - 1;
        reach_r = (th > 8) ? 7 : th - 1;
        if ($urandom_range(99) >= 25) begin
            for (int k = 0; k < 32 && !found; k++) begin
                case ($urandom_range(3))
                    0: begin
                        col = 8'($urandom);
                        row = 8'($urandom);
                    end
                    1: begin
                        col = 8'($urandom_range(tw - 1));
                        row = 8'($urandom_range(th - 1));
                    end
                    default: begin
                        col = 8'($urandom_range(reach_c));
                        row = 8'(th - 1 - $urandom_range(reach_r));
                    end
                endcase
                addr  = texel_address(col, row);
                found = (addr < 0) || texel_loaded[addr];
            end
        end
        if (found) begin
            issue_read(col, row);
        end else begin
            issue_load(8'($urandom), 8'($urandom), 8'($urandom));
        end
    endtask

    // Stop sending, wait for every outstanding texel, then let trailing loads settle.
    task automatic wait_for_results();
        i_valid <= 1'b0;
        while (awaiting != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_index idx, logic [8:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(negedge i_clk);
    endtask

    task automatic set_config(int unsigned cap, int unsigned w, int unsigned h, bit gray);
        wait_for_results();
        write_reg(CFG_TEX_MAX_LOG2, 9'(cap));
        write_reg(CFG_SRC_WIDTH, 9'(w));
        write_reg(CFG_SRC_HEIGHT, 9'(h));
        write_reg(CFG_SRC_IS_GRAY, 9'(gray));
        i_cfg_we <= 1'b0;
        cap_m    = cap;
        width_m  = w;
        height_m = h;
    endtask

    // One configuration: fill the image (or its start), then random items,
    // with a full pause halfway through.
    task automatic run_setting(int idx, int unsigned cap, int unsigned w,
                               int unsigned h, bit gray);
        int unsigned area;
        int unsigned fills;
        if (idx < 3) begin
            tx_gap_pct   = 37;
            rx_stall_pct = 66;
        end else if (idx < 6) begin
            tx_gap_pct   = 66;
            rx_stall_pct = 37;
        end else begin
            tx_gap_pct   = 0;
            rx_stall_pct = 0;
        end
        set_config(cap, w, h, gray);
        area  = clamp_side(w) * clamp_side(h);
        fills = (area == 0) ? 2 : ((area < 24) ? area : 24);
        for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
            if (n == ITEMS_PER_SETTING / 2) begin
                wait_for_results();
            end
            if (n < fills) begin
                issue_load(8'($urandom), 8'($urandom), 8'($urandom));
            end else begin
                random_item();
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Reset settings: 256x256 RGB source, extreme pixel bytes on the
        // first source row, read back from the top texture row.
        issue_load(8'h00, 8'h00, 8'h00);
        issue_load(8'hFF, 8'hFF, 8'hFF);
        issue_load(8'hA5, 8'h5A, 8'hC3);
        issue_read(8'd0, 8'd255);
        issue_read(8'd1, 8'd255);
        issue_read(8'd2, 8'd255);

        // 3x2 gray source with an oversized log2 limit: the load pointer
        // wraps, gray expands the red byte, and reads fall off each edge.
        set_config(15, 3, 2, 1'b1);
        issue_load(8'h80, 8'h01, 8'h02);
        issue_load(8'h7F, 8'hFE, 8'hFD);
        issue_load(8'h3C, 8'hC3, 8'h99);
        issue_load(8'h11, 8'h22, 8'h33);
        issue_read(8'd0, 8'd1);
        issue_read(8'd3, 8'd0);
        issue_read(8'd4, 8'd0);
        issue_read(8'd0, 8'd2);
        issue_read(8'd255, 8'd255);
        issue_read(8'd1, 8'd0);

        // Zero width: texture one texel wide, every in-range read maps to column 0.
        set_config(15, 0, 2, 1'b1);
        issue_read(8'd0, 8'd1);
        issue_read(8'd0, 8'd0);
        issue_read(8'd1, 8'd0);
        issue_load(8'hF0, 8'h0F, 8'hAA);
        issue_read(8'd0, 8'd0);

        // Random part across several configurations.
        run_setting(0, 3, 5, 3, 1'b0);
        run_setting(1, 8, 1, 1, 1'b1);
        run_setting(2, 0, 7, 9, 1'b0);
        run_setting(3, 15, 16, 4, 1'b1);
        run_setting(4, 2, 511, 300, 1'b0);
        run_setting(5, 8, 0, 6, 1'b1);
        run_setting(6, 4, 12, 0, 1'b0);
        run_setting(7, 9, 256, 511, 1'b1);

        wait_for_results();
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: filelist.f
src/p2tr_pkg.sv
src/p2tr_front.sv
src/p2tr_fifo.sv
src/p2tr_back.sv
src/pow2_texture_nearest_resample.sv
sim/texture_read_checker.sv
sim/pow2_texture_nearest_resample_tb.sv
